/* rtl/core/amgt_pkg.sv */
// amgt_pkg: shared widths, command codes and sequencer states for the
// adjacency matrix graph traversal block. No dependencies.
`default_nettype none

package amgt_pkg;

  // fixed field widths
  localparam int COMMAND_W   = 2;
  localparam int VERTEX_W    = 4;
  localparam int COUNT_W     = 5;
  // number of vertices a vertex field can name
  localparam int VERTEX_SPAN = 1 << VERTEX_W;

  // default size and register reset
  localparam int                 DEF_MAX_VERTICES   = 16;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(16);

  // command codes
  typedef enum logic [COMMAND_W-1:0] {
    CMD_ADD_EDGE = 2'd0,
    CMD_DFS      = 2'd1,
    CMD_BFS      = 2'd2
  } cmd_t;

  // traversal sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLOAD,
    ST_DSCAN,
    ST_BPOP,
    ST_BSCAN,
    ST_FINISH
  } state_t;

  // edge write into the matrix
  typedef struct packed {
    logic                en;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
  } edge_wr_t;

  // single bit lookup in the matrix
  typedef struct packed {
    logic [VERTEX_W-1:0] row;
    logic [VERTEX_W-1:0] col;
  } probe_t;

endpackage

`default_nettype wire

/* rtl/core/amgt_if.sv */
// amgt_if: valid/ready channel interfaces for command beats and result beats.
// Depends on amgt_pkg for field widths.
`default_nettype none

interface amgt_in_if import amgt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [COMMAND_W-1:0] command;
  logic [VERTEX_W-1:0]  first_vertex;
  logic [VERTEX_W-1:0]  second_vertex;

  modport source (output valid, command, first_vertex, second_vertex, input ready);
  modport sink   (input valid, command, first_vertex, second_vertex, output ready);
endinterface

interface amgt_out_if import amgt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] vertex;
  logic                last;
  logic                error;

  modport source (output valid, vertex, last, error, input ready);
  modport sink   (input valid, vertex, last, error, output ready);
endinterface

`default_nettype wire

/* rtl/core/adjacency_matrix_graph_traversal_top.sv */
// adjacency_matrix_graph_traversal_top: graph store and dfs/bfs traversal sequencer.
// Depends on amgt_pkg, amgt_in_if / amgt_out_if and amgt_matrix.
//
//   channel  dir  beat carries                          handshake
//   in_ch    in   command, first_vertex, second_vertex  valid/ready
//   out_ch   out  vertex, last, error                   valid/ready
//   cfg      in   cfg_wr_data (vertex_count)            cfg_wr_en, no wait
//
// add edge and unused commands need no sequencer pass. a traversal tests one matrix bit
// per cycle through the shared neighbor probe while the result output is not stalled,
// scanning each visited vertex's row (dfs also reloads the scan position after each
// stack pop). an out of range start goes straight to finish with a single error beat.
// synchronous reset clears the matrix, marks and control; no clearing pass.
// a stalled result stops the sequencer only when a second result is ready to go.

`default_nettype none

module adjacency_matrix_graph_traversal_top import amgt_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [COUNT_W-1:0] cfg_wr_data,
  amgt_in_if.sink                 in_ch,
  amgt_out_if.source              out_ch
);

  localparam int VTX = (MAX_VERTICES < VERTEX_SPAN) ? MAX_VERTICES : VERTEX_SPAN;
  localparam int VW  = $clog2(VTX);
  localparam int CW  = $clog2(VTX + 1);

  // configuration
  logic [COUNT_W-1:0] vertex_count;
  logic [CW-1:0]      n_live;

  // sequencer state
  state_t         state, state_next;
  logic [CW-1:0]  depth, depth_m1;
  logic [CW-1:0]  head, tail;
  logic [VTX-1:0] visited;
  logic [VW-1:0]  cur_v;
  logic [CW-1:0]  scan_idx;
  logic           pend_valid;
  logic [VW-1:0]  pend_v;
  logic           pend_err;

  // stack and queue storage
  logic [VW-1:0] stk_v [VTX];
  logic [CW-1:0] stk_i [VTX];
  logic [VW-1:0] q_v   [VTX];

  // output register
  logic                out_valid;
  logic [VERTEX_W-1:0] out_vertex;
  logic                out_last;
  logic                out_error;

  // control
  logic     accept, is_dfs, is_bfs, start_bad;
  logic     start_dfs, start_bfs, start_err;
  logic     scan_end, adj_bit, hit, can_push, emit_ok;
  logic     dfs_take, dfs_step, dfs_pop, dfs_load;
  logic     bfs_pop, bfs_take, bfs_step;
  logic     push, push_last;
  edge_wr_t edge_wr;
  probe_t   probe;

  // vertex count register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RESET;
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  assign n_live = (vertex_count > COUNT_W'(VTX)) ? CW'(VTX) : vertex_count[CW-1:0];

  // matrix and shared neighbor probe
  amgt_matrix #(.MAX_VERTICES(MAX_VERTICES)) u_matrix (
    .clk     (clk),
    .rst     (rst),
    .edge_wr (edge_wr),
    .probe   (probe),
    .adj_bit (adj_bit)
  );

  assign probe.row = VERTEX_W'(cur_v);
  assign probe.col = scan_idx[VERTEX_W-1:0];
  assign scan_end  = (scan_idx >= n_live);
  assign hit       = adj_bit & ~visited[scan_idx[VW-1:0]];
  assign depth_m1  = depth - CW'(1);
  assign can_push  = ~out_valid | out_ch.ready;
  assign emit_ok   = ~pend_valid | can_push;

  // input decode
  assign accept    = in_ch.valid & in_ch.ready;
  assign is_dfs    = (in_ch.command == CMD_DFS);
  assign is_bfs    = (in_ch.command == CMD_BFS);
  assign start_bad = (COUNT_W'(in_ch.first_vertex) >= COUNT_W'(n_live));

  always_comb begin
    edge_wr.en = accept && (in_ch.command == CMD_ADD_EDGE) && !start_bad &&
                 (COUNT_W'(in_ch.second_vertex) < COUNT_W'(n_live));
    edge_wr.a  = in_ch.first_vertex;
    edge_wr.b  = in_ch.second_vertex;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (is_dfs || is_bfs)) begin
          if (start_bad) begin
            state_next = ST_FINISH;
          end else if (is_dfs) begin
            state_next = ST_DSCAN;
          end else begin
            state_next = ST_BPOP;
          end
        end
      end
      ST_DLOAD: state_next = ST_DSCAN;
      ST_DSCAN: begin
        if (scan_end) begin
          state_next = (depth == CW'(1)) ? ST_FINISH : ST_DLOAD;
        end
      end
      ST_BPOP: begin
        if (head == tail) begin
          state_next = ST_FINISH;
        end else if (emit_ok) begin
          state_next = ST_BSCAN;
        end
      end
      ST_BSCAN: begin
        if (scan_end) begin
          state_next = ST_BPOP;
        end
      end
      ST_FINISH: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer actions
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    start_dfs   = accept && is_dfs && !start_bad;
    start_bfs   = accept && is_bfs && !start_bad;
    start_err   = accept && (is_dfs || is_bfs) && start_bad;
    dfs_take    = (state == ST_DSCAN) && !scan_end && hit && can_push;
    dfs_step    = (state == ST_DSCAN) && !scan_end && !hit;
    dfs_pop     = (state == ST_DSCAN) && scan_end;
    dfs_load    = (state == ST_DLOAD);
    bfs_pop     = (state == ST_BPOP) && (head != tail) && emit_ok;
    bfs_take    = (state == ST_BSCAN) && !scan_end && hit;
    bfs_step    = (state == ST_BSCAN) && !scan_end;
    push_last   = (state == ST_FINISH) && can_push;
    push        = dfs_take || (bfs_pop && pend_valid) || push_last;
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      depth      <= '0;
      head       <= '0;
      tail       <= '0;
      visited    <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start_dfs) begin
        visited    <= VTX'(1) << in_ch.first_vertex[VW-1:0];
        depth      <= CW'(1);
        pend_valid <= 1'b1;
      end
      if (start_bfs) begin
        visited    <= VTX'(1) << in_ch.first_vertex[VW-1:0];
        head       <= '0;
        tail       <= CW'(1);
        pend_valid <= 1'b0;
      end
      if (start_err) begin
        pend_valid <= 1'b1;
      end
      if (dfs_take) begin
        visited[scan_idx[VW-1:0]] <= 1'b1;
        depth                     <= depth + CW'(1);
      end
      if (dfs_pop) begin
        depth <= depth_m1;
      end
      if (bfs_pop) begin
        head       <= head + CW'(1);
        pend_valid <= 1'b1;
      end
      if (bfs_take) begin
        visited[scan_idx[VW-1:0]] <= 1'b1;
        tail                      <= tail + CW'(1);
      end
      if (push_last) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // walk position and pending result
  always_ff @(posedge clk) begin
    if (start_dfs || start_bfs) begin
      cur_v    <= in_ch.first_vertex[VW-1:0];
      scan_idx <= '0;
      pend_v   <= in_ch.first_vertex[VW-1:0];
      pend_err <= 1'b0;
    end
    if (start_err) begin
      pend_v   <= '0;
      pend_err <= 1'b1;
    end
    if (dfs_take) begin
      cur_v    <= scan_idx[VW-1:0];
      scan_idx <= '0;
      pend_v   <= scan_idx[VW-1:0];
    end
    if (dfs_step || bfs_step) begin
      scan_idx <= scan_idx + CW'(1);
    end
    if (dfs_load) begin
      cur_v    <= stk_v[depth_m1[VW-1:0]];
      scan_idx <= stk_i[depth_m1[VW-1:0]];
    end
    if (bfs_pop) begin
      cur_v    <= q_v[head[VW-1:0]];
      scan_idx <= '0;
      pend_v   <= q_v[head[VW-1:0]];
      pend_err <= 1'b0;
    end
  end

  // dfs stack: resume point of the parent, fresh entry for the child
  always_ff @(posedge clk) begin
    if (start_dfs) begin
      stk_v[0] <= in_ch.first_vertex[VW-1:0];
      stk_i[0] <= '0;
    end
    if (dfs_take) begin
      stk_i[depth_m1[VW-1:0]] <= scan_idx + CW'(1);
      stk_v[depth[VW-1:0]]    <= scan_idx[VW-1:0];
      stk_i[depth[VW-1:0]]    <= '0;
    end
  end

  // bfs queue
  always_ff @(posedge clk) begin
    if (start_bfs) begin
      q_v[0] <= in_ch.first_vertex[VW-1:0];
    end
    if (bfs_take) begin
      q_v[tail[VW-1:0]] <= scan_idx[VW-1:0];
    end
  end

  // output register, holds one beat while the sequencer runs on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_vertex <= VERTEX_W'(pend_v);
      out_last   <= push_last;
      out_error  <= pend_err;
    end
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.vertex = out_vertex;
  assign out_ch.last   = out_last;
  assign out_ch.error  = out_error;

  // checks
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    head <= tail)
    else $error("queue head passed tail");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CW'(VTX))
    else $error("stack depth beyond vertex limit");

  a_finish_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> pend_valid)
    else $error("traversal finished with no result pending");

  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_error) |-> (out_last && (out_vertex == '0)))
    else $error("error beat is not a single last beat on vertex zero");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && (is_dfs || is_bfs)) |=> !in_ch.ready)
    else $error("traversal start left the input ready");

endmodule

`default_nettype wire

/* rtl/core/amgt_matrix.sv */
// amgt_matrix: symmetric bit adjacency matrix with edge write and one bit probe.
// Depends on amgt_pkg for edge_wr_t and probe_t.
`default_nettype none

module amgt_matrix import amgt_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire edge_wr_t edge_wr,
  input  wire probe_t   probe,
  output logic          adj_bit
);

  localparam int VTX = (MAX_VERTICES < VERTEX_SPAN) ? MAX_VERTICES : VERTEX_SPAN;
  localparam int VW  = $clog2(VTX);

  logic [VTX-1:0] rows [VTX];

  // set both symmetric bits of an edge
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < VTX; r++) begin
        rows[r] <= '0;
      end
    end else if (edge_wr.en) begin
      rows[edge_wr.a[VW-1:0]][edge_wr.b[VW-1:0]] <= 1'b1;
      rows[edge_wr.b[VW-1:0]][edge_wr.a[VW-1:0]] <= 1'b1;
    end
  end

  // neighbor bit lookup
  assign adj_bit = rows[probe.row[VW-1:0]][probe.col[VW-1:0]];

endmodule

`default_nettype wire
